// ===== hdl/drlc_pkg.sv =====
// ============================================================================
// drlc_pkg - shared types and constants of the disc read timing cache
// Field widths, register indexes, status codes and the token that walks
// the chain of cache cells.
// ============================================================================
package drlc_pkg;

   // Field widths
   localparam int ADDR_W     = 36;
   localparam int LEN_W      = 25;
   localparam int TIME_W     = 63;
   localparam int RATE_W     = 20;
   localparam int SEEK_W     = 16;
   localparam int CAPREG_W   = 9;
   localparam int CSR_W      = 20;
   localparam int CSR_ADDR_W = 2;
   localparam int STATUS_W   = 2;

   // Stream packing
   localparam int REQ_W       = 128;
   localparam int REQ_OFF_LSB = 0;
   localparam int REQ_LEN_LSB = REQ_OFF_LSB + ADDR_W;
   localparam int REQ_NOW_LSB = REQ_LEN_LSB + LEN_W;
   localparam int RSP_W       = 72;

   // Block geometry and sequential-read window
   localparam int BLOCK_BYTES_LOG2 = 16;
   localparam int SEQ_WINDOW_LOG2  = 20;
   localparam int TAG_W            = ADDR_W - BLOCK_BYTES_LOG2;
   localparam int REM_W            = ADDR_W + 1 - BLOCK_BYTES_LOG2;

   // Drive time arithmetic
   localparam int RATE_SHIFT = 10;                 // KiB to bytes
   localparam int PROD_W     = 45;                 // length times one million
   localparam int QUOT_W     = PROD_W - RATE_SHIFT;
   localparam int MS_W       = 26;                 // seek time in microseconds
   localparam int DUR_W      = QUOT_W + 1;
   localparam logic [19:0] US_PER_S  = 20'd1000000;
   localparam logic [9:0]  US_PER_MS = 10'd1000;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_READ_RATE    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEEK_TIME    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CACHE_BLOCKS = 2'd2;

   // Register reset values
   localparam logic [RATE_W-1:0]   RATE_RST = 20'd16200;
   localparam logic [SEEK_W-1:0]   SEEK_RST = 16'd80;
   localparam logic [CAPREG_W-1:0] CAP_RST  = 9'd256;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_INSTANT = 2'd0;
   localparam logic [STATUS_W-1:0] ST_HIT     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SEQ     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SEEK    = 2'd3;

   // Chain operation: probe only, or move-to-front / insert
   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOOK,
      OP_INS
   } drlc_op_type;

   // Token handed from cell to cell, one cell per cycle
   typedef struct packed {
      drlc_op_type      op;
      logic             last;    // final token of a burst
      logic             trim;    // drop entries at or beyond capacity
      logic             found;   // tag matched (probe) or insertion settled
      logic             cvalid;  // carried entry valid
      logic [TAG_W-1:0] ctag;    // carried entry tag
      logic [TAG_W-1:0] tag;     // block being probed or inserted
   } drlc_tok_type;

endpackage

// ===== hdl/drlc_cell.sv =====
// ============================================================================
// drlc_cell - one cache entry of the recency-ordered chain
// Holds one block tag; cell position is its recency rank. A passing token
// probes the tag, or shifts the carried entry in and the held one onward.
// ============================================================================
module drlc_cell import drlc_pkg::*; #(
   parameter int IDX   = 0,
   parameter int CAP_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CAP_W-1:0] cap,
   input  drlc_tok_type     up_tok,
   output drlc_tok_type     dn_tok
);

   logic             valid_ff, valid_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   drlc_tok_type     tok_ff, tok_in;
   logic             match;
   logic             beyond;

   assign match  = valid_ff && (tag_ff == up_tok.tag);
   assign beyond = (CAP_W'(IDX) >= cap);

   // Probe, swap with the carried entry, or drop past capacity
   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      tok_in   = up_tok;
      case (up_tok.op)
         OP_LOOK: begin
            if (match) tok_in.found = 1'b1;
         end
         OP_INS: begin
            if (!up_tok.found) begin
               if (match) begin
                  valid_in     = up_tok.cvalid;
                  tag_in       = up_tok.ctag;
                  tok_in.found = 1'b1;
               end else if (up_tok.trim && beyond) begin
                  valid_in      = 1'b0;
                  tok_in.cvalid = 1'b0;
               end else begin
                  valid_in      = up_tok.cvalid;
                  tag_in        = up_tok.ctag;
                  tok_in.cvalid = valid_ff;
                  tok_in.ctag   = tag_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Hold entry valid bit and the token for the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   // Hold entry tag
   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign dn_tok = tok_ff;

endmodule

// ===== hdl/drlc_div.sv =====
// ============================================================================
// drlc_div - restoring divider, one quotient bit per cycle
// Divides the scaled read length by the drive rate.
// ============================================================================
module drlc_div import drlc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [QUOT_W-1:0] dividend,
   input  logic [RATE_W-1:0] divisor,
   output logic              done,
   output logic [QUOT_W-1:0] quotient
);

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [RATE_W-1:0] rem_ff;
   logic [QUOT_W-1:0] quo_ff;
   logic [RATE_W-1:0] dvs_ff;
   logic [RATE_W:0]   trial;
   logic [RATE_W:0]   diff;
   logic              ge;

   // Trial subtraction of the divisor from the shifted remainder
   assign trial = {rem_ff, quo_ff[QUOT_W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});
   assign diff  = trial - {1'b0, dvs_ff};

   // Count iterations
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift dividend bits in, quotient bits out
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
         quo_ff <= {quo_ff[QUOT_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/disc_read_lru_cache_timing.sv =====
// ============================================================================
// disc_read_lru_cache_timing - drive read timing with an LRU block cache
// Answers each read request with a status and completion time, keeping the
// recently read blocks in a chain of cells ordered by recency.
// ============================================================================
// Usage:
//   req_* carries one read request (offset, length, current time); rsp_*
//   returns one result per request (status, completion time). csr_* writes
//   read rate, seek time and cache capacity; the user does so only while
//   the block is idle; the block does not enforce it. Requests are taken
//   one at a time: req_tready is high only between requests, and a finished
//   result waits in the rsp register while the next request is already accepted.
//   Steps, with N = CACHE_ENTRIES cells and k covered blocks:
//     zero rate or zero length: straight to the output step, no chain access.
//     cache hit: a probe burst of k tokens, then a refresh burst of k
//       tokens, each passing all N cells of the chain.
//     drive read: probe burst, multiply, divide, timing, then an insert
//       burst. After a cache_blocks write, inserts go one block at a
//       time (a probe, then an insert) until the first new block is
//       placed and entries past capacity are dropped. Zero capacity skips all bursts.
//   Every burst must clear all cells before the next step begins.
//   Reset empties the cache, parks the head at zero and clears the busy
//   time. A stalled rsp holds its result; the block then finishes the
//   current request and waits with it until the register frees up.
// ============================================================================
module disc_read_lru_cache_timing import drlc_pkg::*; #(
   parameter int CACHE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // byte_offset, read_length, now_us
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // status, done_us
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int CAP_W = $clog2(CACHE_ENTRIES + 1);
   localparam int CMP_W = (CAP_W > CAPREG_W) ? CAP_W : CAPREG_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOK,
      S_LWAIT,
      S_TOUCH,
      S_TWAIT,
      S_MUL,
      S_DIV,
      S_TIME,
      S_INS,
      S_INS_W,
      S_INS_L,
      S_INS_M,
      S_INS_MW,
      S_OUT
   } state_type;

   function automatic drlc_tok_type make_tok(input drlc_op_type op, input logic last,
                                             input logic trim, input logic [TAG_W-1:0] tag);
      drlc_tok_type t;
      t.op     = op;
      t.last   = last;
      t.trim   = trim;
      t.found  = 1'b0;
      t.cvalid = 1'b1;
      t.ctag   = tag;
      t.tag    = tag;
      return t;
   endfunction

   // Configuration registers
   logic [RATE_W-1:0]   rate_ff;
   logic [SEEK_W-1:0]   seek_ff;
   logic [CAPREG_W-1:0] capreg_ff;

   // Control state
   state_type           state_ff;
   logic                overfull_ff;
   logic                hit_ff;
   logic                found_ff;
   logic                div_start_ff;
   drlc_tok_type        issue_ff;

   // Request and timing payload
   logic [ADDR_W-1:0]   off_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [TAG_W-1:0]    first_ff;
   logic [TAG_W-1:0]    blk_ff;
   logic [REM_W-1:0]    span_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [MS_W-1:0]     seekt_ff;
   logic                seek_flag_ff;
   logic [DUR_W-1:0]    dur_ff;
   logic [TIME_W-1:0]   start_ff;
   logic [ADDR_W:0]     head_ff;
   logic [TIME_W-1:0]   busy_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [TIME_W-1:0]   res_done_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [TIME_W-1:0]   rsp_done_ff;

   // Request fields and derived values
   logic [ADDR_W-1:0]   req_off;
   logic [LEN_W-1:0]    req_len;
   logic [TIME_W-1:0]   req_now;
   logic [ADDR_W:0]     end_c;
   logic [TAG_W-1:0]    first_c;
   logic [REM_W-1:0]    last_c;
   logic [REM_W-1:0]    span_c;
   logic [ADDR_W+1:0]   diff_c;
   logic [ADDR_W+1:0]   dist_c;
   logic                seek_c;
   logic [TIME_W:0]     sum_c;
   logic [TIME_W-1:0]   sat_c;
   logic [CMP_W-1:0]    capreg_x;
   logic [CMP_W-1:0]    cap_x;
   logic [CAP_W-1:0]    cap;
   logic                div_done;
   logic [QUOT_W-1:0]   quot;
   drlc_tok_type        link [CACHE_ENTRIES+1];
   drlc_tok_type        tail_tok;

   assign req_off = req_tdata[REQ_OFF_LSB +: ADDR_W];
   assign req_len = req_tdata[REQ_LEN_LSB +: LEN_W];
   assign req_now = req_tdata[REQ_NOW_LSB +: TIME_W];

   // Covered block range
   assign end_c   = {1'b0, req_off} + (ADDR_W+1)'(req_len) - (ADDR_W+1)'(1);
   assign first_c = req_off[ADDR_W-1:BLOCK_BYTES_LOG2];
   assign last_c  = end_c[ADDR_W:BLOCK_BYTES_LOG2];
   assign span_c  = last_c - {1'b0, first_c};

   // Head distance against the sequential window
   assign diff_c = {2'b00, off_ff} - {1'b0, head_ff};
   assign dist_c = diff_c[ADDR_W+1] ? (~diff_c + 1'b1) : diff_c;
   assign seek_c = (dist_c > ((ADDR_W+2)'(1) << SEQ_WINDOW_LOG2));

   // Saturating completion time
   assign sum_c = {1'b0, start_ff} + (TIME_W+1)'(dur_ff);
   assign sat_c = sum_c[TIME_W] ? {TIME_W{1'b1}} : sum_c[TIME_W-1:0];

   // Effective capacity
   assign capreg_x = CMP_W'(capreg_ff);
   assign cap_x    = (capreg_x > CMP_W'(CACHE_ENTRIES)) ? CMP_W'(CACHE_ENTRIES) : capreg_x;
   assign cap      = cap_x[CAP_W-1:0];

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= RATE_RST;
         seek_ff   <= SEEK_RST;
         capreg_ff <= CAP_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_READ_RATE:    rate_ff   <= csr_wdata[RATE_W-1:0];
            CSR_SEEK_TIME:    seek_ff   <= csr_wdata[SEEK_W-1:0];
            CSR_CACHE_BLOCKS: capreg_ff <= csr_wdata[CAPREG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Chain of cache cells, most recent first
   assign link[0]  = issue_ff;
   assign tail_tok = link[CACHE_ENTRIES];

   for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
      drlc_cell #(
         .IDX   (i),
         .CAP_W (CAP_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .cap    (cap),
         .up_tok (link[i]),
         .dn_tok (link[i+1])
      );
   end

   drlc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (prod_ff[PROD_W-1:RATE_SHIFT]),
      .divisor  (rate_ff),
      .done     (div_done),
      .quotient (quot)
   );

   // Sequence one request through probe, refresh, timing and insert
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         overfull_ff  <= 1'b0;
         div_start_ff <= 1'b0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         busy_ff      <= '0;
      end else begin
         issue_ff.op  <= OP_NONE;
         div_start_ff <= 1'b0;

         // Drop a taken result
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;

         // Collect probe outcomes leaving the chain
         if (tail_tok.op == OP_LOOK && !tail_tok.found) hit_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  off_ff   <= req_off;
                  len_ff   <= req_len;
                  now_ff   <= req_now;
                  first_ff <= first_c;
                  blk_ff   <= first_c;
                  span_ff  <= span_c;
                  rem_ff   <= span_c;
                  hit_ff   <= 1'b1;
                  if (rate_ff == '0 || req_len == '0) begin
                     res_status_ff <= ST_INSTANT;
                     res_done_ff   <= req_now;
                     state_ff      <= S_OUT;
                  end else if (cap != '0) begin
                     state_ff <= S_LOOK;
                  end else begin
                     state_ff <= S_MUL;
                  end
               end
            end
            S_LOOK: begin
               issue_ff <= make_tok(OP_LOOK, rem_ff == '0, 1'b0, blk_ff);
               if (rem_ff == '0) begin
                  state_ff <= S_LWAIT;
               end else begin
                  blk_ff <= blk_ff + 1'b1;
                  rem_ff <= rem_ff - 1'b1;
               end
            end
            S_LWAIT: begin
               if (tail_tok.op != OP_NONE && tail_tok.last) begin
                  blk_ff <= first_ff;
                  rem_ff <= span_ff;
                  if (hit_ff && tail_tok.found) state_ff <= S_TOUCH;
                  else state_ff <= S_MUL;
               end
            end
            S_TOUCH: begin
               issue_ff <= make_tok(OP_INS, rem_ff == '0, 1'b0, blk_ff);
               if (rem_ff == '0) begin
                  state_ff <= S_TWAIT;
               end else begin
                  blk_ff <= blk_ff + 1'b1;
                  rem_ff <= rem_ff - 1'b1;
               end
            end
            S_TWAIT: begin
               if (tail_tok.op != OP_NONE && tail_tok.last) begin
                  res_status_ff <= ST_HIT;
                  res_done_ff   <= now_ff;
                  state_ff      <= S_OUT;
               end
            end
            S_MUL: begin
               prod_ff      <= PROD_W'(len_ff) * PROD_W'(US_PER_S);
               seekt_ff     <= MS_W'(seek_ff) * MS_W'(US_PER_MS);
               seek_flag_ff <= seek_c;
               div_start_ff <= 1'b1;
               state_ff     <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  dur_ff   <= DUR_W'(quot) + (seek_flag_ff ? DUR_W'(seekt_ff) : DUR_W'(0));
                  head_ff  <= {1'b0, off_ff} + (ADDR_W+1)'(len_ff);
                  start_ff <= (busy_ff > now_ff) ? busy_ff : now_ff;
                  state_ff <= S_TIME;
               end
            end
            S_TIME: begin
               busy_ff       <= sat_c;
               res_done_ff   <= sat_c;
               res_status_ff <= seek_flag_ff ? ST_SEEK : ST_SEQ;
               blk_ff        <= first_ff;
               rem_ff        <= span_ff;
               state_ff      <= (cap != '0) ? S_INS : S_OUT;
            end
            S_INS: begin
               if (overfull_ff) begin
                  issue_ff <= make_tok(OP_LOOK, 1'b1, 1'b0, blk_ff);
                  state_ff <= S_INS_L;
               end else begin
                  issue_ff <= make_tok(OP_INS, rem_ff == '0, 1'b1, blk_ff);
                  if (rem_ff == '0) begin
                     state_ff <= S_INS_W;
                  end else begin
                     blk_ff <= blk_ff + 1'b1;
                     rem_ff <= rem_ff - 1'b1;
                  end
               end
            end
            S_INS_W: begin
               if (tail_tok.op != OP_NONE && tail_tok.last) state_ff <= S_OUT;
            end
            S_INS_L: begin
               if (tail_tok.op != OP_NONE && tail_tok.last) begin
                  found_ff <= tail_tok.found;
                  state_ff <= S_INS_M;
               end
            end
            S_INS_M: begin
               issue_ff <= make_tok(OP_INS, 1'b1, !found_ff, blk_ff);
               state_ff <= S_INS_MW;
            end
            S_INS_MW: begin
               if (tail_tok.op != OP_NONE && tail_tok.last) begin
                  if (!found_ff) overfull_ff <= 1'b0;
                  if (rem_ff == '0) begin
                     state_ff <= S_OUT;
                  end else begin
                     blk_ff   <= blk_ff + 1'b1;
                     rem_ff   <= rem_ff - 1'b1;
                     state_ff <= S_INS;
                  end
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_done_ff   <= res_done_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // A capacity write may leave entries past the new capacity
         if (csr_we && csr_addr == CSR_CACHE_BLOCKS) overfull_ff <= 1'b1;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-TIME_W-STATUS_W){1'b0}}, rsp_done_ff, rsp_status_ff};

   // Chain is empty whenever a new request can be taken
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (tail_tok.op == OP_NONE))
      else $error("token still in the cell chain while idle");

   // Divider only finishes while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide step");

   // No token enters the chain with the cache disabled
   a_no_cache_no_tok: assert property (@(posedge clock) disable iff (reset)
      (issue_ff.op != OP_NONE) |-> (cap != '0))
      else $error("chain token issued with zero capacity");

   // A finished result waits while the output register is still full
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_OUT))
      else $error("result dropped while the response was stalled");

endmodule
